>>> rtl/unsigned_to_ascii_digits_unit_macros.svh
// Assertion macros for the ASCII digit unit.
`ifndef UNSIGNED_TO_ASCII_DIGITS_UNIT_MACROS_SVH
`define UNSIGNED_TO_ASCII_DIGITS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define U2A_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define U2A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/u2a_pkg.sv
package u2a_pkg;

	// Operation codes
	localparam logic [1:0] OP_DEC           = 2'd0;
	localparam logic [1:0] OP_HEX_LOWER     = 2'd1;
	localparam logic [1:0] OP_HEX_UPPER     = 2'd2;
	localparam logic [1:0] OP_HEX_UPPER_ALT = 2'd3;

	// ASCII characters
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_X_LOWER = 8'h78;
	localparam logic [7:0] CH_X_UPPER = 8'h58;

	// Digit tables
	localparam logic [7:0] HEX_LOWER [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};
	localparam logic [7:0] HEX_UPPER [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// Commands to the digit shift register
	typedef struct packed {
		logic load;      // take a new value
		logic load_hex;  // load the value straight into the nibbles
		logic step;      // one double-dabble step
		logic shift;     // drop the top digit
	} dig_ctrl_t;

endpackage

>>> rtl/u2a_dabble.sv
module u2a_dabble
	import u2a_pkg::*;
#(
	parameter int VALUE_WIDTH = 64,
	parameter int NDIG        = 20
) (
	input  logic                   clk,
	input  dig_ctrl_t              ctrl,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic [3:0]             top_digit
);

	localparam int DW = NDIG * 4;

	logic [VALUE_WIDTH-1:0] val_q;
	logic [DW-1:0]          dig_q;
	logic [DW-1:0]          adj;

	// add 3 to every digit of 5 or more
	always_comb begin
		for (int g = 0; g < NDIG; g++) begin
			adj[g*4 +: 4] = (dig_q[g*4 +: 4] >= 4'd5) ? dig_q[g*4 +: 4] + 4'd3
			                                           : dig_q[g*4 +: 4];
		end
	end

	// value and digit shift registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= value;
			dig_q <= ctrl.load_hex ? DW'(value) : '0;
		end else if (ctrl.step) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			dig_q <= {adj[DW-2:0], val_q[VALUE_WIDTH-1]};
		end else if (ctrl.shift) begin
			dig_q <= {dig_q[DW-5:0], 4'd0};
		end
	end

	assign top_digit = dig_q[DW-1 -: 4];

endmodule

>>> rtl/u2a_char_enc.sv
module u2a_char_enc
	import u2a_pkg::*;
(
	input  logic [3:0] digit,
	input  logic       upper,
	output logic [7:0] character
);

	// digit to ASCII, case chosen by mode
	assign character = upper ? HEX_UPPER[digit] : HEX_LOWER[digit];

endmodule

>>> rtl/unsigned_to_ascii_digits_unit.sv
// Converts an unsigned value to ASCII decimal or hex digits, one character per
// cycle on character/last, flagged by a one-cycle strobe; the receiver cannot
// stall, so every strobed word must be captured when it appears. A new item is
// taken when start is high and busy is low. Decimal conversion runs a bit-serial
// double-dabble over the VALUE_WIDTH bits (hex loads the nibbles directly), then
// the digit register drops NDIG - min(count, NDIG) unused top digits one per
// cycle, and then the optional two-character prefix and the count digits go out
// one per cycle, count being digit_count saturated at MAX_DIGITS. NDIG is 20
// for 64 bits. Each word is registered and appears in the cycle after its emit
// cycle.
`include "unsigned_to_ascii_digits_unit_macros.svh"

module unsigned_to_ascii_digits_unit
	import u2a_pkg::*;
#(
	parameter int MAX_DIGITS  = 62,
	parameter int VALUE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	input  logic [1:0]  operation,
	input  logic        prefix_en,
	input  logic [5:0]  digit_count,
	output logic        strobe,
	output logic [7:0]  character,
	output logic        last
);

	localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int NDIG       = (BCD_DIGITS > HEX_DIGITS) ? BCD_DIGITS : HEX_DIGITS;
	localparam int CMAX0      = (VALUE_WIDTH > MAX_DIGITS) ? VALUE_WIDTH : MAX_DIGITS;
	localparam int CMAX       = (CMAX0 > NDIG) ? CMAX0 : NDIG;
	localparam int LW         = $clog2(CMAX + 1);
	localparam logic [LW-1:0] NDIG_L = LW'(NDIG);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CONV  = 7'b0000010,
		S_SKIP  = 7'b0000100,
		S_PFX0  = 7'b0001000,
		S_PFX1  = 7'b0010000,
		S_LEAD  = 7'b0100000,
		S_DIGIT = 7'b1000000
	} state_t;

	state_t        state_q, state_d;
	state_t        nxt_lead, nxt_pfx, nxt_skip, nxt_conv;
	logic [LW-1:0] ctr_q, ctr_d;
	logic [LW-1:0] lead_q, used_q, skip_q;
	logic          pfx_q, upper_q, hex_q;

	logic          accept;
	logic          in_hex, in_upper, in_pfx;
	logic [5:0]    cnt_sat;
	logic [LW-1:0] cnt_l, in_lead, in_used;

	dig_ctrl_t     dctrl;
	logic [3:0]    top_digit;
	logic [7:0]    digit_char;

	logic          emit;
	logic [7:0]    char_d;
	logic          last_d;
	logic          strobe_q, last_q;
	logic [7:0]    char_q;

	assign accept = start && (state_q == S_IDLE);

	// decode the incoming word
	assign in_hex   = (operation != OP_DEC);
	assign in_upper = (operation == OP_HEX_UPPER) || (operation == OP_HEX_UPPER_ALT);
	assign in_pfx   = in_hex && prefix_en && (value[VALUE_WIDTH-1:0] != '0);
	assign cnt_sat  = (digit_count > 6'(MAX_DIGITS)) ? 6'(MAX_DIGITS) : digit_count;
	assign cnt_l    = LW'(cnt_sat);
	assign in_lead  = (cnt_l > NDIG_L) ? cnt_l - NDIG_L : '0;
	assign in_used  = (cnt_l > NDIG_L) ? NDIG_L : cnt_l;

	// per-item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			lead_q  <= in_lead;
			used_q  <= in_used;
			skip_q  <= NDIG_L - in_used;
			pfx_q   <= in_pfx;
			upper_q <= in_upper;
			hex_q   <= in_hex;
		end
	end

	// phase order, skipping empty phases
	assign nxt_lead = (used_q != '0) ? S_DIGIT : S_IDLE;
	assign nxt_pfx  = (lead_q != '0) ? S_LEAD : nxt_lead;
	assign nxt_skip = pfx_q ? S_PFX0 : nxt_pfx;
	assign nxt_conv = (skip_q != '0) ? S_SKIP : nxt_skip;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_CONV;
			S_CONV:  if (ctr_q == '0) state_d = nxt_conv;
			S_SKIP:  if (ctr_q == '0) state_d = nxt_skip;
			S_PFX0:  state_d = S_PFX1;
			S_PFX1:  state_d = nxt_pfx;
			S_LEAD:  if (ctr_q == '0) state_d = nxt_lead;
			S_DIGIT: if (ctr_q == '0) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// phase counter, loaded on phase entry
	always_comb begin
		ctr_d = ctr_q - 1'b1;
		if (state_d != state_q) begin
			unique case (state_d)
				S_CONV:  ctr_d = in_hex ? '0 : LW'(VALUE_WIDTH - 1);
				S_SKIP:  ctr_d = skip_q - 1'b1;
				S_LEAD:  ctr_d = lead_q - 1'b1;
				S_DIGIT: ctr_d = used_q - 1'b1;
				default: ctr_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctr_q   <= '0;
		end else begin
			state_q <= state_d;
			ctr_q   <= ctr_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// digit register commands
	assign dctrl.load     = accept;
	assign dctrl.load_hex = in_hex;
	assign dctrl.step     = (state_q == S_CONV) && !hex_q;
	assign dctrl.shift    = (state_q == S_SKIP) || (state_q == S_DIGIT);

	u2a_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NDIG       (NDIG)
	) u_dabble (
		.clk      (clk),
		.ctrl     (dctrl),
		.value    (value[VALUE_WIDTH-1:0]),
		.top_digit(top_digit)
	);

	u2a_char_enc u_enc (
		.digit    (top_digit),
		.upper    (upper_q),
		.character(digit_char)
	);

	// character selection
	always_comb begin
		emit   = 1'b0;
		char_d = CH_ZERO;
		last_d = 1'b0;
		unique case (state_q)
			S_PFX0: begin
				emit = 1'b1;
			end
			S_PFX1: begin
				emit   = 1'b1;
				char_d = upper_q ? CH_X_UPPER : CH_X_LOWER;
				last_d = (lead_q == '0) && (used_q == '0);
			end
			S_LEAD: begin
				emit   = 1'b1;
				last_d = (ctr_q == '0) && (used_q == '0);
			end
			S_DIGIT: begin
				emit   = 1'b1;
				char_d = digit_char;
				last_d = (ctr_q == '0);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= emit;
			last_q   <= emit && last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) char_q <= char_d;
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

	// checks
	`U2A_ASSERT_NOW(a_last_strobed, last, strobe, "last without strobe")
	`U2A_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
	`U2A_ASSERT_NEXT(a_gap_after_last, strobe && last, !strobe, "word right after last")
	`U2A_ASSERT_NOW(a_strobe_busy, strobe, $past(busy), "strobe without an item at work")

endmodule
